@@ rtl/cfse_pkg.sv @@
// Shared types and constants for the continued-fraction segment encoder.
// Used by cfse_mac, cfse_seq and the top level; depends on nothing.
package cfse_pkg;

  // Field widths
  localparam int VAL_W  = 57;  // numerator / denominator width
  localparam int PIX_W  = 8;   // pixel width
  localparam int TERM_W = 9;   // pixel + offset, up to 257
  localparam int LEN_W  = 3;   // segment length register width
  localparam int CNT_W  = $clog2(TERM_W + 1);

  localparam logic [TERM_W-1:0] TERM_OFFSET = TERM_W'(2);
  localparam logic [LEN_W-1:0]  RESET_LEN   = LEN_W'(6);
  localparam logic [LEN_W-1:0]  MAX_SEG_LEN = LEN_W'(7);

  // Request into the shared shift-add unit
  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  acc_init;
    logic [VAL_W-1:0]  mcand_init;
    logic [TERM_W-1:0] mult_init;
  } mac_req_t;

  // Response from the shared shift-add unit
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } mac_rsp_t;

endpackage

@@ rtl/continued_fraction_segment_encoder.sv @@
// Continued-fraction segment encoder: each pixel plus 2 is a term of a
// continued fraction; every segment_length pixels (1..7, reset 6, zero acts
// as 1) one fraction numerator/denominator is produced, already in lowest
// terms. A trailing partial segment produces nothing. Each pixel is accepted
// and then makes two passes through the shared shift-add unit (numerator,
// then denominator), each taking one bit of the 9-bit term per cycle and
// ending in a done pulse; the last pixel of a segment then loads the result
// register, later while an earlier result still waits. in_ready is low while
// a pixel is being worked on. A finished result waits in its own register,
// so the next pixel is taken meanwhile.
// Depends on cfse_pkg, cfse_seq and cfse_mac.
module continued_fraction_segment_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfse_pkg::PIX_W-1:0]  pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cfse_pkg::VAL_W-1:0]  numerator,
  output logic [cfse_pkg::VAL_W-1:0]  denominator,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cfse_pkg::LEN_W-1:0]  segment_length
);
  import cfse_pkg::*;

  logic [LEN_W-1:0] seg_len;
  mac_req_t         mac_req;
  mac_rsp_t         mac_rsp;

  // Segment length register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= RESET_LEN;
    end else if (cfg_valid && cfg_ready) begin
      seg_len <= segment_length;
    end
  end

  cfse_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel       (pixel),
    .seg_len     (seg_len),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .numerator   (numerator),
    .denominator (denominator),
    .mac_req     (mac_req),
    .mac_rsp     (mac_rsp)
  );

  cfse_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  // A pixel request keeps in_ready low in the cycle after its acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready still high after a pixel request");

  // Every term is at least 2, so a result fraction is above one
  a_frac_above_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (numerator > denominator) && (denominator != '0))
    else $error("result fraction not above one");

  // A new result is only loaded while a pixel is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a pixel in work");

endmodule

@@ rtl/cfse_mac.sv @@
// Shared shift-add multiply-accumulate unit: result = acc_init + mcand * mult.
// One multiplier bit per cycle over all TERM_W bits of mult. Uses cfse_pkg.
module cfse_mac (
  input  logic               clk,
  input  logic               rst,
  input  cfse_pkg::mac_req_t req,
  output cfse_pkg::mac_rsp_t rsp
);
  import cfse_pkg::*;

  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  mcand;
  logic [TERM_W-1:0] mult;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(TERM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one conditional add and one shift per cycle (mod 2^VAL_W)
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= req.acc_init;
      mcand <= req.mcand_init;
      mult  <= req.mult_init;
    end else if (busy) begin
      if (mult[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[VAL_W-2:0], 1'b0};
      mult  <= {1'b0, mult[TERM_W-1:1]};
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

endmodule

@@ rtl/cfse_seq.sv @@
// Sequencer: holds the convergents, drives the shared MAC twice per pixel
// and owns the result register. Uses cfse_pkg.
module cfse_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cfse_pkg::PIX_W-1:0]  pixel,
  input  logic [cfse_pkg::LEN_W-1:0]  seg_len,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cfse_pkg::VAL_W-1:0]  numerator,
  output logic [cfse_pkg::VAL_W-1:0]  denominator,
  output cfse_pkg::mac_req_t          mac_req,
  input  cfse_pkg::mac_rsp_t          mac_rsp
);
  import cfse_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NUM,
    S_DEN,
    S_EMIT
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  num_prev;
  logic [VAL_W-1:0]  num_cur;
  logic [VAL_W-1:0]  den_prev;
  logic [VAL_W-1:0]  den_cur;
  logic [LEN_W-1:0]  term_count;
  logic [TERM_W-1:0] term;
  logic [TERM_W-1:0] pix_term;
  logic [LEN_W-1:0]  len_eff;

  assign pix_term = {1'b0, pixel} + TERM_OFFSET;
  assign in_ready = (state == S_IDLE);

  // Effective length: zero acts as one, clamp to the maximum
  always_comb begin
    priority if (seg_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (seg_len > MAX_SEG_LEN) begin
      len_eff = MAX_SEG_LEN;
    end else begin
      len_eff = seg_len;
    end
  end

  // MAC requests: numerator pass on accept, denominator pass after it
  always_comb begin
    mac_req.start = ((state == S_IDLE) && in_valid) ||
                    ((state == S_NUM) && mac_rsp.done);
    if (state == S_IDLE) begin
      mac_req.acc_init   = num_cur;
      mac_req.mcand_init = num_prev;
      mac_req.mult_init  = pix_term;
    end else begin
      mac_req.acc_init   = den_cur;
      mac_req.mcand_init = den_prev;
      mac_req.mult_init  = term;
    end
  end

  // State, convergents and result register.
  // Consecutive convergents p1*q0 - p0*q1 = +/-1, so p/q is already in lowest
  // terms: the gcd is always 1 and the fraction goes out unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      num_prev   <= VAL_W'(1);
      num_cur    <= '0;
      den_prev   <= '0;
      den_cur    <= VAL_W'(1);
      term_count <= '0;
    end else begin
      // the emit state reloads the register itself
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            term       <= pix_term;
            term_count <= term_count + LEN_W'(1);
            state      <= S_NUM;
          end
        end
        S_NUM: begin
          if (mac_rsp.done) begin
            num_cur  <= num_prev;
            num_prev <= mac_rsp.result;
            state    <= S_DEN;
          end
        end
        S_DEN: begin
          if (mac_rsp.done) begin
            den_cur  <= den_prev;
            den_prev <= mac_rsp.result;
            state    <= (term_count >= len_eff) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            numerator   <= num_prev;
            denominator <= den_prev;
            num_prev    <= VAL_W'(1);
            num_cur     <= '0;
            den_prev    <= '0;
            den_cur     <= VAL_W'(1);
            term_count  <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for continued_fraction_segment_encoder: predicts each reduced
// convergent fraction per segment and compares it with every accepted result.
// Depends on cfse_pkg and the top level of the block only.
module tb;
  import cfse_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 48;    // one pixel pass plus result load, with margin
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 1000;  // long receiver back-off
  localparam int IDLE_PCT      = 35;
  localparam int RANDOM_PIXELS = 430;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {OP_PIXEL, OP_SET_LENGTH, OP_DRAIN} stream_kind_t;

  typedef struct {
    stream_kind_t     kind;
    logic [PIX_W-1:0] pix;
    logic [LEN_W-1:0] len;
    bit               no_gap;
  } stream_op_t;

  typedef struct {
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
  } fraction_t;

  // DUT connections
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] pixel = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] numerator;
  logic [VAL_W-1:0] denominator;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] segment_length = '0;

  // Pixel stream and expected fractions
  stream_op_t pixel_stream_q[$];
  stream_op_t stream_head;
  fraction_t  fraction_q[$];
  fraction_t  want_frac;

  // Convergent tracking: latest and previous numerator/denominator
  logic [VAL_W-1:0] p_last, p_older, q_last, q_older;
  logic [LEN_W-1:0] terms_taken;
  logic [LEN_W-1:0] seg_len_shadow;

  // Handshake bookkeeping, updated at the rising edge
  bit dut_live = 1'b0;
  bit in_fire = 1'b0;
  bit cfg_fire = 1'b0;
  int quiet_cycles = 0;
  int fractions_seen = 0;
  int mismatch_cnt = 0;

  // Driver and receiver working variables
  bit nxt_in_valid, nxt_cfg_valid;
  int hold_left = 0;
  bit hold_done = 1'b0;

  continued_fraction_segment_encoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel          (pixel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .numerator      (numerator),
    .denominator    (denominator),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .segment_length (segment_length)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [VAL_W-1:0] euclid_gcd(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  task automatic clear_convergents();
    p_last      = VAL_W'(1);
    p_older     = '0;
    q_last      = '0;
    q_older     = VAL_W'(1);
    terms_taken = '0;
  endtask

  // One continued-fraction term; closes the segment when enough terms are in
  task automatic advance_convergents(input logic [PIX_W-1:0] pix);
    logic [TERM_W-1:0] term;
    logic [LEN_W-1:0]  eff_len;
    logic [63:0]       p_wide, q_wide;
    logic [VAL_W-1:0]  g;
    fraction_t         f;
    term    = TERM_W'(pix) + TERM_OFFSET;
    // zero length behaves as one
    eff_len = (seg_len_shadow == '0) ? LEN_W'(1) : seg_len_shadow;
    p_wide  = 64'(term) * 64'(p_last) + 64'(p_older);
    q_wide  = 64'(term) * 64'(q_last) + 64'(q_older);
    p_older = p_last;
    p_last  = p_wide[VAL_W-1:0];
    q_older = q_last;
    q_last  = q_wide[VAL_W-1:0];
    terms_taken = terms_taken + 1'b1;
    if (terms_taken >= eff_len) begin
      g = euclid_gcd(p_last, q_last);
      if (g == '0) g = VAL_W'(1);
      f.num = p_last / g;
      f.den = q_last / g;
      fraction_q.push_back(f);
      clear_convergents();
    end
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit no_gap);
    stream_op_t op;
    op.kind   = OP_PIXEL;
    op.pix    = pix;
    op.len    = '0;
    op.no_gap = no_gap;
    pixel_stream_q.push_back(op);
  endtask

  task automatic push_length(input logic [LEN_W-1:0] len);
    stream_op_t op;
    op.kind   = OP_SET_LENGTH;
    op.pix    = '0;
    op.len    = len;
    op.no_gap = 1'b0;
    pixel_stream_q.push_back(op);
  endtask

  task automatic push_drain();
    stream_op_t op;
    op.kind   = OP_DRAIN;
    op.pix    = '0;
    op.len    = '0;
    op.no_gap = 1'b0;
    pixel_stream_q.push_back(op);
  endtask

  // Monitor: sample handshakes, check results, update the prediction
  always @(posedge clk) begin
    if (rst) begin
      seg_len_shadow = RESET_LEN;
      clear_convergents();
      dut_live     = 1'b0;
      in_fire      = 1'b0;
      cfg_fire     = 1'b0;
      quiet_cycles = 0;
    end else begin
      dut_live = 1'b1;
      in_fire  = in_valid && in_ready;
      cfg_fire = cfg_valid && cfg_ready;
      if (out_valid && out_ready) begin
        fractions_seen++;
        if (fraction_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("%0t: unexpected fraction %0d/%0d", $realtime, numerator, denominator);
        end else begin
          want_frac = fraction_q.pop_front();
          if (numerator !== want_frac.num || denominator !== want_frac.den) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX)
              $display("%0t: mismatch: num exp %0d got %0d, den exp %0d got %0d",
                       $realtime, want_frac.num, numerator, want_frac.den, denominator);
          end
        end
      end
      if (cfg_fire) seg_len_shadow = segment_length;
      if (in_fire) advance_convergents(pixel);
      if (fraction_q.size() == 0 && !in_valid && !cfg_valid) quiet_cycles++;
      else quiet_cycles = 0;
    end
  end

  // Driver: one stream op at a time, holding each request until accepted
  always @(negedge clk) begin
    if (dut_live && !((in_valid && !in_fire) || (cfg_valid && !cfg_fire))) begin
      nxt_in_valid  = 1'b0;
      nxt_cfg_valid = 1'b0;
      if (pixel_stream_q.size() != 0) begin
        stream_head = pixel_stream_q[0];
        case (stream_head.kind)
          OP_PIXEL: begin
            if (stream_head.no_gap || $urandom_range(99) >= IDLE_PCT) begin
              nxt_in_valid = 1'b1;
              pixel <= stream_head.pix;
              void'(pixel_stream_q.pop_front());
            end
          end
          OP_SET_LENGTH: begin
            // only once the block has gone quiet
            if (quiet_cycles >= SETTLE_CYCLES) begin
              nxt_cfg_valid = 1'b1;
              segment_length <= stream_head.len;
              void'(pixel_stream_q.pop_front());
            end
          end
          OP_DRAIN: begin
            if (fraction_q.size() == 0) void'(pixel_stream_q.pop_front());
          end
          default: void'(pixel_stream_q.pop_front());
        endcase
      end
      in_valid  <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // Receiver: random back-pressure, one long hold, one stretch always ready
  always @(negedge clk) begin
    if (dut_live) begin
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && fractions_seen >= 15 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (fractions_seen >= 30 && fractions_seen < 45) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n;
    int burst;
    int phase;
    logic [PIX_W-1:0] pix;

    // reset length of six, alternating extremes
    for (int i = 0; i < 6; i++) push_pixel((i % 2) ? 8'hFF : 8'h00, 1'b0);
    // zero length acts as one
    push_length(LEN_W'(0));
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hFF, 1'b0);
    // longest segment with largest terms
    push_length(MAX_SEG_LEN);
    for (int i = 0; i < 7; i++) push_pixel(8'hFF, 1'b0);
    // shorter length written mid-segment: next pixel closes it
    push_length(LEN_W'(3));
    push_pixel(8'd1, 1'b0);
    push_pixel(8'd2, 1'b0);
    push_length(LEN_W'(1));
    push_pixel(8'd128, 1'b0);
    // already past the new length when it is written
    push_length(LEN_W'(4));
    push_pixel(8'd10, 1'b0);
    push_pixel(8'd20, 1'b0);
    push_pixel(8'd30, 1'b0);
    push_length(LEN_W'(2));
    push_pixel(8'd40, 1'b0);

    // random bursts; one of them runs without gaps
    n = 0;
    phase = 0;
    while (n < RANDOM_PIXELS) begin
      if ($urandom_range(3) == 0) push_drain();
      else push_length(LEN_W'($urandom_range(7)));
      burst = $urandom_range(30, 60);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(7) == 0) pix = $urandom_range(1) ? 8'hFF : 8'h00;
        else pix = PIX_W'($urandom_range(255));
        push_pixel(pix, phase == 3);
      end
      n += burst;
      phase++;
    end

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (pixel_stream_q.size() != 0 || in_valid || cfg_valid || fraction_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && fraction_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
